@@ rtl/positional_list_insert_delete_top_assert.svh @@
// Assertion macros for the positional list block.
// Used by the port checker; relies on clk and rst_n being in scope.
`ifndef POSITIONAL_LIST_INSERT_DELETE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PLID_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("positional list: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define PLID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("positional list: next-cycle check failed");

`endif

@@ rtl/plid_pkg.sv @@
// Shared types and constants for the positional list block.
// No dependencies; used by the cell and the top level.
package plid_pkg;

  localparam int POS_W = 5;
  localparam int VAL_W = 32;
  localparam int LEN_W = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_POS_ERR = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // Broadcast from the top level to every cell of the row.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage

@@ rtl/plid_cell.sv @@
// One storage cell of the list row: holds a single element.
// Depends on plid_pkg for the control struct.
module plid_cell #(
  parameter int CAPACITY = 16,
  parameter int IDX      = 0
) (
  input  logic                         clk,
  input  plid_pkg::cell_ctrl_t         ctrl,
  input  logic [plid_pkg::VAL_W-1:0]   left_val,
  input  logic [plid_pkg::VAL_W-1:0]   right_val,
  output logic [plid_pkg::VAL_W-1:0]   val
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = ((CNT_W > plid_pkg::POS_W) ? CNT_W : plid_pkg::POS_W) + 1;
  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  logic [CW-1:0]                pos_ext;
  logic [plid_pkg::VAL_W-1:0]   val_r;
  logic [plid_pkg::VAL_W-1:0]   val_nxt;

  assign pos_ext = {{(CW - plid_pkg::POS_W){1'b0}}, ctrl.pos};

  // On insert, cells above the position take from the head side; on delete,
  // cells at or above the position take from the tail side.
  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins) begin
      if (MY_IDX == pos_ext) begin
        val_nxt = ctrl.value;
      end else if (MY_IDX > pos_ext) begin
        val_nxt = left_val;
      end
    end else if (ctrl.del && (MY_IDX >= pos_ext)) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

@@ rtl/positional_list_insert_delete_top.sv @@
// Top level of the positional list: control, length counter and cell row.
// Depends on plid_pkg and plid_cell.
//
// Usage:
//   An item (in_mode, in_position, in_item_value) is taken at a rising edge
//   with start high and busy low. busy stays low: the row of cells shifts
//   every element in parallel, so an item can be taken in every cycle.
//   Insert places the value at the position (0 to length), moving later
//   elements one cell towards the tail; delete removes the element at the
//   position (0 to length-1), moving later elements towards the head.
//   Every item gives one result on out_status, out_removed_value and
//   out_new_length, marked by out_strobe for one cycle, the cycle after the
//   item was taken. Throughput is one item per cycle, set by the single
//   register stage of the cells and result.
//   The receiver cannot stall; it must take each result when it appears.
//   A synchronous reset (rst_n low) empties the list and clears the strobe;
//   element contents are not cleared, as only entries below the length are
//   ever read.
module positional_list_insert_delete_top #(
  parameter int CAPACITY = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic                               in_mode,
  input  logic [plid_pkg::POS_W-1:0]         in_position,
  input  logic signed [plid_pkg::VAL_W-1:0]  in_item_value,
  output logic                               out_strobe,
  output logic [1:0]                         out_status,
  output logic signed [plid_pkg::VAL_W-1:0]  out_removed_value,
  output logic [plid_pkg::LEN_W-1:0]         out_new_length
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CW    = ((CNT_W > plid_pkg::POS_W) ? CNT_W : plid_pkg::POS_W) + 1;
  localparam int LW    = plid_pkg::LEN_W;
  localparam logic [CW-1:0] CAP_EXT = CW'(CAPACITY);

  logic                          accept;
  logic [CW-1:0]                 pos_ext;
  logic [CW-1:0]                 cnt_ext;
  plid_pkg::status_t             status;
  logic                          ins_ok;
  logic                          del_ok;
  plid_pkg::cell_ctrl_t          ctrl;
  logic [plid_pkg::VAL_W-1:0]    cell_val [CAPACITY];
  logic [plid_pkg::VAL_W-1:0]    left_in  [CAPACITY];
  logic [plid_pkg::VAL_W-1:0]    right_in [CAPACITY];
  logic [plid_pkg::VAL_W-1:0]    removed;

  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              count_nxt;
  logic                          strobe_r;
  plid_pkg::status_t             status_r;
  logic [plid_pkg::VAL_W-1:0]    removed_r;
  logic [LW-1:0]                 len_r;

  // The row updates every element in parallel, so the block never holds items off.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign pos_ext = {{(CW - plid_pkg::POS_W){1'b0}}, in_position};
  assign cnt_ext = {{(CW - CNT_W){1'b0}}, count_r};

  // The position check takes precedence over the full check.
  always_comb begin
    status = plid_pkg::ST_OK;
    if (in_mode == plid_pkg::MODE_INSERT) begin
      if (pos_ext > cnt_ext) begin
        status = plid_pkg::ST_POS_ERR;
      end else if (cnt_ext == CAP_EXT) begin
        status = plid_pkg::ST_FULL;
      end
    end else begin
      if (pos_ext >= cnt_ext) begin
        status = plid_pkg::ST_POS_ERR;
      end
    end
  end

  assign ins_ok = accept && (in_mode == plid_pkg::MODE_INSERT) && (status == plid_pkg::ST_OK);
  assign del_ok = accept && (in_mode == plid_pkg::MODE_DELETE) && (status == plid_pkg::ST_OK);

  always_comb begin
    ctrl.ins   = ins_ok;
    ctrl.del   = del_ok;
    ctrl.pos   = in_position;
    ctrl.value = in_item_value;
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign left_in[g] = '0;
    end else begin : g_mid_l
      assign left_in[g] = cell_val[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_in[g] = '0;
    end else begin : g_mid_r
      assign right_in[g] = cell_val[g+1];
    end

    plid_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (g)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left_val  (left_in[g]),
      .right_val (right_in[g]),
      .val       (cell_val[g])
    );
  end

  // Only read when the delete is in range, so the index is always valid then.
  assign removed = del_ok ? cell_val[pos_ext[IDX_W-1:0]] : '0;

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (del_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= accept;
    end
    status_r  <= status;
    removed_r <= removed;
    len_r     <= LW'(count_nxt);
  end

  assign out_strobe        = strobe_r;
  assign out_status        = status_r;
  assign out_removed_value = removed_r;
  assign out_new_length    = len_r;

endmodule

@@ rtl/plid_checker.sv @@
// Port-level checks for the positional list top level, bound to it below.
// Depends on plid_pkg and the assertion macro header.
`include "positional_list_insert_delete_top_assert.svh"

module plid_checker #(
  parameter int CAPACITY = 16
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_strobe,
  input logic [1:0]                         out_status,
  input logic signed [plid_pkg::VAL_W-1:0]  out_removed_value,
  input logic [plid_pkg::LEN_W-1:0]         out_new_length
);

  localparam int LW = plid_pkg::LEN_W;

  logic res_failed;
  logic res_full;

  assign res_failed = out_strobe && (out_status != plid_pkg::ST_OK);
  assign res_full   = out_strobe && (out_status == plid_pkg::ST_FULL);

  // Every item taken gives exactly one result in the following cycle.
  `PLID_ASSERT_NEXT(a_result_follows, start && !busy, out_strobe)
  `PLID_ASSERT_NEXT(a_no_spurious_result, !(start && !busy), !out_strobe)

  // A failed operation never reports a removed element.
  `PLID_ASSERT_NOW(a_fail_no_removed, res_failed, out_removed_value == '0)

  // A full report can only come when the list holds CAPACITY elements.
  `PLID_ASSERT_NOW(a_full_at_capacity, res_full, out_new_length == LW'(CAPACITY))

endmodule

bind positional_list_insert_delete_top plid_checker #(.CAPACITY(CAPACITY)) u_plid_checker (.*);

@@ test/tb_positional_list_insert_delete_top.sv @@
// Testbench for positional_list_insert_delete_top: a directed table, then random
// insert and delete items, each result checked against a model of the list kept here.
// Depends on plid_pkg and the RTL of the block; needs nothing else.
module tb_positional_list_insert_delete_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY        = 16;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int PHASES          = 13;
  localparam int ITEMS_PER_PHASE = 100;

  typedef struct {
    logic                              mode;
    logic [plid_pkg::POS_W-1:0]        pos;
    logic signed [plid_pkg::VAL_W-1:0] value;
    bit                                typed;
    plid_pkg::status_t                 status;
    logic signed [plid_pkg::VAL_W-1:0] removed;
    logic [plid_pkg::LEN_W-1:0]        length;
  } list_step_t;

  typedef struct {
    plid_pkg::status_t                 status;
    logic signed [plid_pkg::VAL_W-1:0] removed;
    logic [plid_pkg::LEN_W-1:0]        length;
  } list_result_t;

  logic                              clk;
  logic                              rst_n;
  logic                              start;
  logic                              busy;
  logic                              in_mode;
  logic [plid_pkg::POS_W-1:0]        in_position;
  logic signed [plid_pkg::VAL_W-1:0] in_item_value;
  logic                              out_strobe;
  logic [1:0]                        out_status;
  logic signed [plid_pkg::VAL_W-1:0] out_removed_value;
  logic [plid_pkg::LEN_W-1:0]        out_new_length;

  // Model of the list contents, advanced when an item is accepted.
  logic signed [plid_pkg::VAL_W-1:0] list_vals [CAPACITY];
  int                                list_len = 0;

  list_result_t pending_results[$];
  list_step_t   directed_steps[$];
  list_step_t   cur_step;

  int fail_count   = 0;
  int cycle_count  = 0;
  int n_insert_ok  = 0;
  int n_delete_ok  = 0;
  int n_pos_err    = 0;
  int n_full       = 0;
  int n_results    = 0;

  positional_list_insert_delete_top #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_position      (in_position),
    .in_item_value    (in_item_value),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_removed_value(out_removed_value),
    .out_new_length   (out_new_length)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic list_result_t apply_to_list(logic mode, logic [plid_pkg::POS_W-1:0] pos,
                                                 logic signed [plid_pkg::VAL_W-1:0] value);
    list_result_t res;
    int p;
    p = int'(pos);
    res.status  = plid_pkg::ST_OK;
    res.removed = '0;
    if (mode == plid_pkg::MODE_INSERT) begin
      if (p > list_len) begin
        res.status = plid_pkg::ST_POS_ERR;
      end else if (list_len >= CAPACITY) begin
        res.status = plid_pkg::ST_FULL;
      end else begin
        for (int i = list_len; i > p; i--) list_vals[i] = list_vals[i-1];
        list_vals[p] = value;
        list_len++;
      end
    end else if (p >= list_len) begin
      res.status = plid_pkg::ST_POS_ERR;
    end else begin
      res.removed = list_vals[p];
      for (int i = p; i < list_len - 1; i++) list_vals[i] = list_vals[i+1];
      list_len--;
    end
    res.length = plid_pkg::LEN_W'(list_len);
    return res;
  endfunction

  task automatic add_step(logic mode, int pos, logic signed [plid_pkg::VAL_W-1:0] value,
                          bit typed, plid_pkg::status_t status,
                          logic signed [plid_pkg::VAL_W-1:0] removed, int length);
    list_step_t s;
    s.mode    = mode;
    s.pos     = plid_pkg::POS_W'(pos);
    s.value   = value;
    s.typed   = typed;
    s.status  = status;
    s.removed = removed;
    s.length  = plid_pkg::LEN_W'(length);
    directed_steps.push_back(s);
  endtask

  // Most positions are legal, with weight on the head, the tail and just past it.
  function automatic list_step_t random_step(int insert_pct);
    list_step_t s;
    int limit;
    int r;
    int p;
    s.mode = ($urandom_range(99) < insert_pct) ? plid_pkg::MODE_INSERT : plid_pkg::MODE_DELETE;
    limit  = (s.mode == plid_pkg::MODE_INSERT) ? list_len : list_len - 1;
    r      = $urandom_range(99);
    if (r < 8 || limit < 0) p = $urandom_range(31);
    else if (r < 16) p = limit + 1 + $urandom_range(2);
    else if (r < 30) p = 0;
    else if (r < 44) p = limit;
    else p = $urandom_range(limit);
    s.pos = plid_pkg::POS_W'(p);
    r     = $urandom_range(99);
    if (r < 10) s.value = 32'sh7FFF_FFFF;
    else if (r < 20) s.value = 32'sh8000_0000;
    else if (r < 25) s.value = '0;
    else if (r < 30) s.value = -32'sd1;
    else s.value = $urandom;
    s.typed   = 1'b0;
    s.status  = plid_pkg::ST_OK;
    s.removed = '0;
    s.length  = '0;
    return s;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(2, 1);
    if (r < 97) return $urandom_range(8, 3);
    return $urandom_range(40, 15);
  endfunction

  // Start is low while idle; the item ports carry noise that must be ignored.
  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start         = 1'b0;
      in_mode       = 1'($urandom_range(1));
      in_position   = plid_pkg::POS_W'($urandom_range(31));
      in_item_value = $urandom;
    end
  endtask

  task automatic send_item(list_step_t s);
    @(negedge clk);
    cur_step      = s;
    in_mode       = s.mode;
    in_position   = s.pos;
    in_item_value = s.value;
    start         = 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Results of the cycle just ended are checked before the item taken at this
  // edge is added to the model.
  always @(posedge clk) begin
    list_result_t want;
    list_result_t res;
    if (rst_n === 1'b1) begin
      if (out_strobe === 1'b1) begin
        n_results++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected item: status %0d removed %0d length %0d", $time,
                   out_status, out_removed_value, out_new_length);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: out_status expected %0d got %0d", $time, want.status, out_status);
            fail_count++;
          end
          if (out_removed_value !== want.removed) begin
            $display("%0t: out_removed_value expected %0d got %0d", $time, want.removed,
                     out_removed_value);
            fail_count++;
          end
          if (out_new_length !== want.length) begin
            $display("%0t: out_new_length expected %0d got %0d", $time, want.length,
                     out_new_length);
            fail_count++;
          end
        end
      end else if (out_strobe !== 1'b0) begin
        $display("%0t: out_strobe expected 0 got %b", $time, out_strobe);
        fail_count++;
      end
      if (start === 1'b1 && busy === 1'b0) begin
        res = apply_to_list(in_mode, in_position, in_item_value);
        case (res.status)
          plid_pkg::ST_OK: begin
            if (in_mode == plid_pkg::MODE_INSERT) n_insert_ok++; else n_delete_ok++;
          end
          plid_pkg::ST_POS_ERR: n_pos_err++;
          default:              n_full++;
        endcase
        if (cur_step.typed) begin
          want.status  = cur_step.status;
          want.removed = cur_step.removed;
          want.length  = cur_step.length;
          pending_results.push_back(want);
        end else begin
          pending_results.push_back(res);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: run stopped at the cycle limit", $time);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int insert_pct;
    bit burst;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_mode       = plid_pkg::MODE_INSERT;
    in_position   = '0;
    in_item_value = '0;
    cur_step.typed = 1'b0;

    // Empty list, then a single element, then fill to capacity and hit the limits.
    add_step(plid_pkg::MODE_DELETE, 0,  32'sd0,         1, plid_pkg::ST_POS_ERR, 32'sd0, 0);
    add_step(plid_pkg::MODE_INSERT, 1,  32'sd5,         1, plid_pkg::ST_POS_ERR, 32'sd0, 0);
    add_step(plid_pkg::MODE_INSERT, 31, 32'sh7FFF_FFFF, 1, plid_pkg::ST_POS_ERR, 32'sd0, 0);
    add_step(plid_pkg::MODE_INSERT, 0,  32'sh7FFF_FFFF, 1, plid_pkg::ST_OK,      32'sd0, 1);
    add_step(plid_pkg::MODE_DELETE, 0,  -32'sd1,        1, plid_pkg::ST_OK,
             32'sh7FFF_FFFF, 0);
    add_step(plid_pkg::MODE_INSERT, 0,  32'sh8000_0000, 1, plid_pkg::ST_OK,      32'sd0, 1);
    add_step(plid_pkg::MODE_INSERT, 1,  -32'sd1,        1, plid_pkg::ST_OK,      32'sd0, 2);
    add_step(plid_pkg::MODE_INSERT, 0,  32'sd0,         1, plid_pkg::ST_OK,      32'sd0, 3);
    add_step(plid_pkg::MODE_INSERT, 1,  32'sh5555_5555, 0, plid_pkg::ST_OK, 32'sd0, 0);
    add_step(plid_pkg::MODE_INSERT, 4,  32'shAAAA_AAAA, 0, plid_pkg::ST_OK, 32'sd0, 0);
    add_step(plid_pkg::MODE_INSERT, 2,  32'sd1,         0, plid_pkg::ST_OK, 32'sd0, 0);
    add_step(plid_pkg::MODE_INSERT, 6,  32'sd2,         0, plid_pkg::ST_OK, 32'sd0, 0);
    add_step(plid_pkg::MODE_INSERT, 0,  32'sd3,         0, plid_pkg::ST_OK, 32'sd0, 0);
    add_step(plid_pkg::MODE_INSERT, 8,  32'sd4,         0, plid_pkg::ST_OK, 32'sd0, 0);
    add_step(plid_pkg::MODE_INSERT, 5,  32'sd5,         0, plid_pkg::ST_OK, 32'sd0, 0);
    add_step(plid_pkg::MODE_INSERT, 10, 32'sd6,         0, plid_pkg::ST_OK, 32'sd0, 0);
    add_step(plid_pkg::MODE_INSERT, 3,  32'sd7,         0, plid_pkg::ST_OK, 32'sd0, 0);
    add_step(plid_pkg::MODE_INSERT, 12, 32'sd8,         0, plid_pkg::ST_OK, 32'sd0, 0);
    add_step(plid_pkg::MODE_INSERT, 7,  32'sd9,         0, plid_pkg::ST_OK, 32'sd0, 0);
    add_step(plid_pkg::MODE_INSERT, 14, 32'sd10,        0, plid_pkg::ST_OK, 32'sd0, 0);
    add_step(plid_pkg::MODE_INSERT, 15, 32'sd11,        1, plid_pkg::ST_OK,      32'sd0, 16);
    add_step(plid_pkg::MODE_INSERT, 16, 32'sd99,        1, plid_pkg::ST_FULL,    32'sd0, 16);
    add_step(plid_pkg::MODE_INSERT, 17, 32'sd99,        1, plid_pkg::ST_POS_ERR, 32'sd0, 16);
    add_step(plid_pkg::MODE_DELETE, 16, 32'sd0,         1, plid_pkg::ST_POS_ERR, 32'sd0, 16);
    add_step(plid_pkg::MODE_DELETE, 15, 32'sd0,         1, plid_pkg::ST_OK,      32'sd11, 15);
    add_step(plid_pkg::MODE_DELETE, 0,  32'sd0,         0, plid_pkg::ST_OK, 32'sd0, 0);

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_steps[i]) begin
      idle_cycles(gap_len());
      send_item(directed_steps[i]);
    end

    // Phases lean towards filling, draining or neither, so the list keeps
    // running into both the full and the empty state.
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 3)
        0:       insert_pct = 75;
        1:       insert_pct = 30;
        default: insert_pct = 55;
      endcase
      burst = (ph % 4 == 2);
      if (ph % 5 == 4) begin
        // Drop start first, or the last item would be taken again while waiting.
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (!burst) idle_cycles(gap_len());
        send_item(random_step(insert_pct));
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    $display("Checked %0d results: %0d inserts, %0d deletes, %0d position errors, %0d full.",
             n_results, n_insert_ok, n_delete_ok, n_pos_err, n_full);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ positional_list_insert_delete_top.f @@
+incdir+rtl
rtl/plid_pkg.sv
rtl/plid_cell.sv
rtl/positional_list_insert_delete_top.sv
rtl/plid_checker.sv
test/tb_positional_list_insert_delete_top.sv
